FILE: rtl/sqch_pkg.sv
// Shared types, constants and helpers for the square-wave sound channel.
package sqch_pkg;

    localparam int unsigned LenStep  = 16384;
    localparam int unsigned EnvStep  = 65536;
    localparam int unsigned SwpStep  = 32768;
    localparam int unsigned MaxAmp   = 8191;
    localparam int unsigned ClkRate  = 4194304;

    localparam logic [2:0] REG_SWEEP = 3'd0;
    localparam logic [2:0] REG_DUTY  = 3'd1;
    localparam logic [2:0] REG_ENV   = 3'd2;
    localparam logic [2:0] REG_FLO   = 3'd3;
    localparam logic [2:0] REG_FHI   = 3'd4;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // divider width: dividends are the 32-bit tick counter and the fixed rates
    localparam int DivW = 32;

    typedef enum logic [3:0] {
        S_IDLE, S_APPLY, S_LEN, S_ENV, S_STEP,
        S_FREQ, S_PER, S_POS, S_OUT
    } t_state;

    typedef enum logic {
        D_FREQ, D_PER
    } t_dsel;

    typedef struct packed {
        logic  latch_in;    // take the input word
        logic  apply;       // register write or trigger, add ticks
        logic  div_start;
        t_dsel div_sel;
        logic  step;        // act on crossings
        logic  make_pos;    // start pos division
        logic  finish;      // sample into output register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_sts;

    function automatic logic [7:0] duty_mask(input logic [1:0] sel);
        logic [7:0] m;
        begin
            case (sel)
                2'd0:    m = 8'h01;
                2'd1:    m = 8'h81;
                2'd2:    m = 8'h87;
                default: m = 8'h7E;
            endcase
            return m;
        end
    endfunction

endpackage

FILE: rtl/sqch_div.sv
// Restoring divider, one quotient bit a cycle.
module sqch_div
    import sqch_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DivW-1:0] i_num,
    input  logic [DivW-1:0] i_den,
    output logic [DivW-1:0] o_quo,
    output logic            o_busy,
    output logic            o_done
);
    logic [DivW-1:0] r_quo, n_quo, r_rem, n_rem, r_den;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy, r_done;
    logic [DivW:0]   trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_quo[DivW-1]} - {1'b0, r_den};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 6'(DivW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[DivW]) begin
                n_rem = trial[DivW-1:0];
                n_quo = {r_quo[DivW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DivW-2:0], r_quo[DivW-1]};
                n_quo = {r_quo[DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

FILE: rtl/sqch_ctrl.sv
// Sequencer for one item: apply, crossing checks, sample build.
module sqch_ctrl
    import sqch_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_is_tick,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.div_sel = D_FREQ;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = i_is_tick ? S_LEN : S_FREQ;
            end
            S_LEN: begin
                // the datapath launches the crossing divisions on its own
                n_state = S_ENV;
            end
            S_ENV: begin
                // envelope pair done, sweep pair under way
                if (i_sts.div_done) n_state = S_STEP;
            end
            S_STEP: begin
                if (i_sts.div_done) begin
                    o_cmd.step = 1'b1;
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = D_FREQ;
                    n_state = S_PER;
                end
            end
            S_PER: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = D_PER;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (i_sts.div_done) begin
                    o_cmd.make_pos = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the finished word until the output register is free
                if (!i_sts.div_busy && i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: rtl/sqch_dp.sv
// Channel state, crossing arithmetic and sample datapath.
module sqch_dp
    import sqch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_mode,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_tick_count,
    input  logic        i_out_ready,
    output logic        o_is_tick,
    output logic        o_out_free,
    output logic        o_out_valid,
    output logic [13:0] o_sample,
    output logic        o_channel_on,
    output t_sts        o_sts
);
    logic [7:0]  r_regs [5];
    logic [3:0]  r_vol, r_svol;
    logic [6:0]  r_len;
    logic        r_en, r_trig;
    logic [31:0] r_cnt, r_old;
    logic        r_mode;
    logic [2:0]  r_idx;
    logic [7:0]  r_data, r_ticks;
    logic        r_ov;
    logic [13:0] r_smp;
    logic        r_son;
    // envelope crossing, kept until the step
    logic        r_env_cross;
    logic [DivW-1:0] r_qa;
    logic [2:0]  r_seq;

    logic            div_start, seq_start;
    logic [DivW-1:0] div_num, div_den, div_quo;
    logic            div_busy, div_done;
    logic [10:0]     fval;
    // step intervals: envelope, sweep
    logic [DivW-1:0] ivl [2];
    logic [2:0]      seq_m1;
    logic            st_sel, cmp_sel;
    logic            len_cross, cmp_cross;
    logic [11:0]     per_den;
    logic [10:0]     delta, sw_sum;
    logic [11:0]     sw_add;
    logic [16:0]     mag;
    logic [2:0]      pos;
    logic [7:0]      dmask;

    assign fval    = {r_regs[REG_FHI][2:0], r_regs[REG_FLO]};
    assign ivl[0]  = DivW'(EnvStep) * DivW'(r_regs[REG_ENV][2:0]);
    assign ivl[1]  = DivW'(SwpStep) * DivW'(r_regs[REG_SWEEP][6:4]);
    assign per_den = 12'd2048 - {1'b0, fval};

    // crossing sequence: 1..2 envelope old/new, 3..4 sweep old/new, done at 5
    assign seq_m1    = r_seq - 3'd1;
    assign st_sel    = seq_m1[1];
    assign cmp_sel   = r_seq[2];
    assign cmp_cross = !r_ov && (ivl[cmp_sel] != '0) && (r_qa < div_quo);
    assign len_cross = !r_ov && ((r_old / LenStep) < (r_cnt / LenStep));

    always_comb begin
        div_start = 1'b0;
        seq_start = 1'b0;
        div_num   = '0;
        div_den   = DivW'(1);
        if (i_cmd.div_start && (i_cmd.div_sel == D_FREQ)) begin
            div_start = 1'b1;
            div_num   = DivW'(131072);
            div_den   = DivW'(per_den);
        end else if (i_cmd.div_start && (i_cmd.div_sel == D_PER)) begin
            div_start = 1'b1;
            div_num   = DivW'(ClkRate);
            div_den   = (div_quo == '0) ? DivW'(1) : div_quo;
        end else if (i_cmd.make_pos) begin
            div_start = 1'b1;
            div_num   = DivW'(r_cnt);
            div_den   = (div_quo[DivW-1:3] == '0) ? DivW'(1) : {3'b0, div_quo[DivW-1:3]};
        end else if ((r_seq == 3'd1 && !div_busy)
                     || (div_done && r_seq >= 3'd2 && r_seq <= 3'd4)) begin
            div_start = 1'b1;
            seq_start = 1'b1;
            div_num   = r_seq[0] ? DivW'(r_old) : DivW'(r_cnt);
            div_den   = (ivl[st_sel] == '0) ? DivW'(1) : ivl[st_sel];
        end
    end

    sqch_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quo  (div_quo),
        .o_busy (div_busy),
        .o_done (div_done)
    );

    assign delta  = fval >> r_regs[REG_SWEEP][2:0];
    assign sw_add = {1'b0, fval} + {1'b0, delta};
    assign sw_sum = r_regs[REG_SWEEP][3] ? (fval - delta)
                  : (sw_add[11] ? 11'd2047 : sw_add[10:0]);
    assign pos    = div_quo[2:0];
    assign mag    = (17'(MaxAmp) * 17'(r_vol)) >> 4;
    assign dmask  = duty_mask(r_regs[REG_DUTY][7:6]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_regs[k] <= '0;
            r_vol <= '0; r_svol <= '0; r_len <= '0;
            r_en <= 1'b0; r_trig <= 1'b0; r_cnt <= '0;
            o_out_valid <= 1'b0; r_seq <= '0; r_env_cross <= 1'b0;
        end else begin
            if (i_cmd.finish) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.apply) begin
                if (r_mode == MODE_TICK) begin
                    r_old <= r_trig ? 32'd0 : r_cnt;
                    {r_ov, r_cnt} <= {1'b0, (r_trig ? 32'd0 : r_cnt)} + 33'(r_ticks);
                    if (r_trig) begin
                        r_trig <= 1'b0;
                        r_en   <= 1'b1;
                        if (r_len == '0) r_len <= 7'd64;
                        r_vol  <= r_svol;
                    end
                    r_seq <= 3'd1;
                end else if (r_idx <= REG_FHI) begin
                    r_regs[r_idx] <= r_data;
                    unique case (r_idx)
                        REG_DUTY: r_len  <= 7'd64 - {1'b0, r_data[5:0]};
                        REG_ENV:  r_svol <= r_data[7:4];
                        REG_FHI:  if (r_data[7]) r_trig <= 1'b1;
                        default: ;
                    endcase
                end
            end
            if (seq_start) r_seq <= r_seq + 3'd1;
            if (div_done && r_seq >= 3'd2) begin
                if (!r_seq[0]) r_qa <= div_quo;
                else if (r_seq == 3'd3) r_env_cross <= cmp_cross;
                if (r_seq == 3'd5) r_seq <= 3'd0;
            end
            // step runs on the cycle the sweep pair completes
            if (i_cmd.step) begin
                if (r_regs[REG_FHI][6] && len_cross && r_len != '0)
                    r_len <= r_len - 7'd1;
                if ((r_regs[REG_FHI][6] && len_cross && r_len == 7'd1)
                    || (cmp_cross && !r_regs[REG_SWEEP][3] && sw_add[11]))
                    r_en <= 1'b0;
                if (r_env_cross) begin
                    if (r_regs[REG_ENV][3]) begin
                        if (r_vol != 4'd15) r_vol <= r_vol + 4'd1;
                    end else if (r_vol != 4'd0) r_vol <= r_vol - 4'd1;
                end
                if (cmp_cross) begin
                    r_regs[REG_FLO] <= sw_sum[7:0];
                    r_regs[REG_FHI] <= {r_regs[REG_FHI][7:3], sw_sum[10:8]};
                end
            end
        end
        if (i_cmd.latch_in) begin
            r_mode <= i_mode; r_idx <= i_reg_index;
            r_data <= i_write_data; r_ticks <= i_tick_count;
        end
        if (i_cmd.finish) begin
            r_son <= r_en;
            if (!r_en) r_smp <= '0;
            else if (dmask[pos]) r_smp <= mag[13:0];
            else r_smp <= 14'd0 - mag[13:0];
        end
    end

    assign o_is_tick    = (r_mode == MODE_TICK);
    assign o_out_free   = !o_out_valid || i_out_ready;
    assign o_sample     = r_smp;
    assign o_channel_on = r_son;
    assign o_sts.div_busy = div_busy || (r_seq != 3'd0);
    assign o_sts.div_done = div_done && (r_seq == 3'd0 || r_seq == 3'd3 || r_seq == 3'd5);
endmodule

FILE: rtl/square_wave_sound_channel.sv
// Top level of the square-wave sound channel: handshake, sequencer, datapath.
//  channel | dir | word                                     | accepted when
//  s_axis  | in  | tdata: mode, reg_index, write_data, tick | tvalid && tready
//  m_axis  | out | tdata: sample, channel_on                | tvalid && tready
// One word at a time through a one-bit-a-cycle divider.
// A tick word runs four crossing divisions and three sample divisions; the next
// word can be taken in the same cycle that its result becomes valid.
// A register write skips the crossing divisions and runs only the sample divisions.
// A stalled receiver holds the finished word in the sequencer until the output
// register is free.
// Reset (synchronous, active low) clears the channel registers and sequencer.
// A result waiting in the output register does not block the next input word.
module square_wave_sound_channel
    import sqch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode, [3:1] reg_index, [11:4] write_data, [19:12] tick_count
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] sample, [14] channel_on
    output logic [15:0] m_axis_tdata
);
    t_cmd        cmd;
    t_sts        sts;
    logic        is_tick, out_free;
    logic [13:0] sample;
    logic        chan_on;

    sqch_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_is_tick (is_tick),
        .i_out_free(out_free),
        .i_sts     (sts),
        .o_in_ready(s_axis_tready),
        .o_cmd     (cmd)
    );

    sqch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (s_axis_tdata[0]),
        .i_reg_index (s_axis_tdata[3:1]),
        .i_write_data(s_axis_tdata[11:4]),
        .i_tick_count(s_axis_tdata[19:12]),
        .i_out_ready (m_axis_tready),
        .o_is_tick   (is_tick),
        .o_out_free  (out_free),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (sample),
        .o_channel_on(chan_on),
        .o_sts       (sts)
    );

    assign m_axis_tdata = {1'b0, chan_on, sample};

    // an item is only taken with the sequencer idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken mid item");
    // disabled channel gives silence
    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[14] |-> m_axis_tdata[13:0] == 14'd0)
        else $error("sample while disabled");
    // start and finish never coincide
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.latch_in && cmd.finish))
        else $error("latch and finish together");
endmodule
